[rtl/sparse_spike_readout_sgd_top_macros.svh]
// Assertion macros shared by the readout RTL.
// Needs nothing; included by ssr_back, the module that checks itself.
`ifndef SPARSE_SPIKE_READOUT_SGD_TOP_MACROS_SVH
`define SPARSE_SPIKE_READOUT_SGD_TOP_MACROS_SVH

// same-cycle implication
`define SSR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ssr_pkg.sv]
// Types, codes and arithmetic helpers of the spike readout.
// No dependencies.
package ssr_pkg;

    // input operation codes
    localparam logic [2:0] OP_LOAD_W = 3'd0;
    localparam logic [2:0] OP_LOAD_B = 3'd1;
    localparam logic [2:0] OP_SPIKE  = 3'd2;
    localparam logic [2:0] OP_ERROR  = 3'd3;
    localparam logic [2:0] OP_UPDATE = 3'd4;

    localparam logic signed [17:0] Q16_ONE = 18'sd65536;
    localparam logic [15:0]        LR_RESET = 16'd66;

    typedef enum logic [2:0] {
        K_LOAD_W,
        K_LOAD_B,
        K_SPIKE,
        K_ERROR,
        K_UPDATE
    } t_kind;

    // one queued work word
    typedef struct packed {
        t_kind              kind;
        logic [5:0]         row;
        logic [12:0]        col;
        logic signed [15:0] val;
        logic signed [17:0] err;
        logic               col_ok;
        logic               last;
    } t_work;

    function automatic logic signed [23:0] sat24(input logic signed [24:0] v);
        if (v > 25'sd8388607) begin
            return 24'sd8388607;
        end else if (v < -25'sd8388608) begin
            return -24'sd8388608;
        end
        return v[23:0];
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
        if (v > 17'sd32767) begin
            return 16'sd32767;
        end else if (v < -17'sd32768) begin
            return -16'sd32768;
        end
        return v[15:0];
    endfunction

    // Q3.32 product to Q4.12, round half up
    function automatic logic signed [15:0] step_of(input logic signed [34:0] p);
        logic signed [35:0] t;
        t = 36'(p) + 36'sd524288;
        return t[35:20];
    endfunction

    // old minus rounded step, saturated
    function automatic logic signed [15:0] descend(input logic signed [15:0] old,
                                                   input logic signed [34:0] p);
        return sat16(17'(old) - 17'(step_of(p)));
    endfunction

endpackage

[rtl/ssr_ifs.sv]
// Valid/ready channel interfaces for input items and logit words.
// Depends on ssr_pkg.
interface ssr_in_if import ssr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [2:0]         operation;
    logic [5:0]         class_row;
    logic [12:0]        input_column;
    logic signed [15:0] load_value;
    logic [16:0]        probability;
    logic [5:0]         target_class;
    logic               last_spike;

    modport source (output valid, operation, class_row, input_column, load_value,
                    probability, target_class, last_spike, input ready);
    modport sink (input valid, operation, class_row, input_column, load_value,
                  probability, target_class, last_spike, output ready);
endinterface

interface ssr_out_if import ssr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [5:0]         class_index;
    logic signed [23:0] logit;
    logic               last_class;

    modport source (output valid, class_index, logit, last_class, input ready);
    modport sink (input valid, class_index, logit, last_class, output ready);
endinterface

[rtl/sparse_spike_readout_sgd_top.sv]
// Spike-driven linear readout with SGD: top level.
// Input channel i_item takes one word per operation: weight load, bias load,
// spike, error or column update. Output channel o_logit returns logit words.
// i_cfg_we / i_cfg_wdata write the learning rate (reset 66); the user must
// write it only while idle, and the block does not enforce this. A front end
// decodes each word and drops no-op items (bad codes, bad rows or columns);
// a two-entry queue feeds the back end, so input keeps flowing while the
// back end works or the output is stalled. Back end time per item is set by
// the registered read of the wide weight row and one multiply stage per step.
// A spike flagged last then emits NUM_CLASSES logit words, class 0 first,
// each by a bias memory read, then add and saturate, with last_class on the
// final one; accumulators clear after it.
// If the receiver stalls, the output register holds its word and emission
// pauses; the queue then fills and i_item.ready drops.
// Reset (synchronous, active low) clears accumulators, stored errors, the
// queue and the output; weight and bias stores hold garbage until loaded.
// No clearing pass is needed after reset.
module sparse_spike_readout_sgd_top import ssr_pkg::*; #(
    parameter int NUM_CLASSES = 64,
    parameter int NUM_INPUTS  = 8192
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    ssr_in_if.sink      i_item,
    ssr_out_if.source   o_logit
);

    logic [15:0] r_lr;
    logic        fq_valid;
    logic        fq_ready;
    t_work       fq_data;
    logic        qb_valid;
    logic        qb_ready;
    t_work       qb_data;

    // learning rate register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr <= LR_RESET;
        end else if (i_cfg_we) begin
            r_lr <= i_cfg_wdata;
        end
    end

    ssr_front #(
        .NUM_CLASSES (NUM_CLASSES),
        .NUM_INPUTS  (NUM_INPUTS)
    ) u_front (
        .i_item    (i_item),
        .i_q_ready (fq_ready),
        .o_q_valid (fq_valid),
        .o_q_data  (fq_data)
    );

    ssr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fq_valid),
        .o_ready (fq_ready),
        .i_data  (fq_data),
        .o_valid (qb_valid),
        .i_ready (qb_ready),
        .o_data  (qb_data)
    );

    ssr_back #(
        .NUM_CLASSES (NUM_CLASSES),
        .NUM_INPUTS  (NUM_INPUTS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_lr      (r_lr),
        .i_q_valid (qb_valid),
        .o_q_ready (qb_ready),
        .i_q_data  (qb_data),
        .o_logit   (o_logit)
    );

endmodule

[rtl/ssr_front.sv]
// Front end: decodes input words, drops no-op items, forms work words.
// Depends on ssr_pkg and ssr_in_if.
module ssr_front import ssr_pkg::*; #(
    parameter int NUM_CLASSES = 64,
    parameter int NUM_INPUTS  = 8192
) (
    ssr_in_if.sink i_item,
    input  logic   i_q_ready,
    output logic   o_q_valid,
    output t_work  o_q_data
);

    logic row_ok;
    logic col_ok;
    logic keep;

    assign row_ok = 32'(i_item.class_row) < NUM_CLASSES;
    assign col_ok = 32'(i_item.input_column) < NUM_INPUTS;

    // classify and build the work word
    always_comb begin
        o_q_data.kind   = K_LOAD_W;
        o_q_data.row    = i_item.class_row;
        o_q_data.col    = i_item.input_column;
        o_q_data.val    = i_item.load_value;
        o_q_data.err    = $signed({1'b0, i_item.probability})
                        - ((i_item.class_row == i_item.target_class) ? Q16_ONE : 18'sd0);
        o_q_data.col_ok = col_ok;
        o_q_data.last   = i_item.last_spike;
        keep            = 1'b0;
        unique case (i_item.operation)
            OP_LOAD_W: begin
                o_q_data.kind = K_LOAD_W;
                keep          = row_ok && col_ok;
            end
            OP_LOAD_B: begin
                o_q_data.kind = K_LOAD_B;
                keep          = row_ok;
            end
            OP_SPIKE: begin
                o_q_data.kind = K_SPIKE;
                keep          = col_ok || i_item.last_spike;
            end
            OP_ERROR: begin
                o_q_data.kind = K_ERROR;
                keep          = row_ok;
            end
            OP_UPDATE: begin
                o_q_data.kind = K_UPDATE;
                keep          = col_ok;
            end
            default: keep = 1'b0;
        endcase
    end

    // dropped words are still taken, only when the queue has room
    assign i_item.ready = i_q_ready;
    assign o_q_valid    = i_item.valid && keep;

endmodule

[rtl/ssr_queue.sv]
// Two-entry work queue between front and back end.
// Depends on ssr_pkg.
module ssr_queue import ssr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_work i_data,
    output logic  o_valid,
    input  logic  i_ready,
    output t_work o_data
);

    t_work      r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_data  = r_slot[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    // payload slots
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wp] <= i_data;
        end
    end

endmodule

[rtl/ssr_back.sv]
// Back end: weight and bias stores, accumulators, SGD steps, logit emission.
// Depends on ssr_pkg, ssr_out_if and the assertion macros.
`include "sparse_spike_readout_sgd_top_macros.svh"
module ssr_back import ssr_pkg::*; #(
    parameter int NUM_CLASSES = 64,
    parameter int NUM_INPUTS  = 8192
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_lr,
    input  logic        i_q_valid,
    output logic        o_q_ready,
    input  t_work       i_q_data,
    ssr_out_if.source   o_logit
);

    localparam int RW = $clog2(NUM_CLASSES);
    localparam int CW = $clog2(NUM_INPUTS);
    localparam logic [RW-1:0] LAST_CLS = RW'(NUM_CLASSES - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_SP_ADD, S_ER_MUL, S_ER_WR, S_UP_MUL, S_UP_WR, S_EM_RD, S_EM_WR
    } t_state;

    t_state                              r_state;
    t_work                               r_work;
    logic [RW-1:0]                       r_cnt;
    logic signed [23:0]                  r_acc  [NUM_CLASSES];
    logic signed [17:0]                  r_err  [NUM_CLASSES];
    logic signed [34:0]                  r_prod [NUM_CLASSES];
    logic signed [34:0]                  r_bprod;
    logic [NUM_CLASSES-1:0][15:0]        r_wold;
    logic signed [15:0]                  r_bold;
    logic                                r_ovalid;
    logic [5:0]                          r_oidx;
    logic signed [23:0]                  r_ologit;
    logic                                r_olast;

    // stores
    logic [NUM_CLASSES-1:0][15:0]        r_wmem [NUM_INPUTS];
    logic [NUM_CLASSES-1:0][15:0]        r_wrd;
    logic signed [15:0]                  r_bmem [NUM_CLASSES];
    logic signed [15:0]                  r_brd;

    logic                                pop;
    logic                                out_free;
    logic                                w_re;
    logic [CW-1:0]                       w_raddr;
    logic [NUM_CLASSES-1:0]              w_we;
    logic [CW-1:0]                       w_waddr;
    logic [NUM_CLASSES-1:0][15:0]        w_wdata;
    logic                                b_we;
    logic [RW-1:0]                       b_waddr;
    logic signed [15:0]                  b_wdata;
    logic [RW-1:0]                       b_raddr;
    logic signed [24:0]                  logit_sum;

    assign o_q_ready = r_state == S_IDLE;
    assign pop       = i_q_valid && o_q_ready;
    assign out_free  = !r_ovalid || o_logit.ready;
    assign logit_sum = 25'(r_brd) + 25'(r_acc[r_cnt]);

    // store port steering
    always_comb begin
        w_re    = pop && (i_q_data.kind == K_SPIKE || i_q_data.kind == K_UPDATE);
        w_raddr = CW'(i_q_data.col);
        w_we    = '0;
        w_waddr = CW'(r_work.col);
        w_wdata = r_wold;
        b_we    = 1'b0;
        b_waddr = RW'(r_work.row);
        b_wdata = descend(r_bold, r_bprod);
        b_raddr = (r_state == S_IDLE) ? RW'(i_q_data.row) : r_cnt;
        if (pop && i_q_data.kind == K_LOAD_W) begin
            w_waddr = CW'(i_q_data.col);
            for (int l = 0; l < NUM_CLASSES; l++) begin
                w_we[l]    = RW'(i_q_data.row) == RW'(l);
                w_wdata[l] = i_q_data.val;
            end
        end else if (r_state == S_UP_WR) begin
            w_we = '1;
            for (int l = 0; l < NUM_CLASSES; l++) begin
                w_wdata[l] = descend(r_wold[l], r_prod[l]);
            end
        end
        if (pop && i_q_data.kind == K_LOAD_B) begin
            b_we    = 1'b1;
            b_waddr = RW'(i_q_data.row);
            b_wdata = i_q_data.val;
        end else if (r_state == S_ER_WR) begin
            b_we = 1'b1;
        end
    end

    // weight memory: one row holds a column for all classes
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < NUM_CLASSES; l++) begin
            if (w_we[l]) begin
                r_wmem[w_waddr][l] <= w_wdata[l];
            end
        end
        if (w_re) begin
            r_wrd <= r_wmem[w_raddr];
        end
    end

    // bias memory
    always_ff @(posedge i_clk) begin
        if (b_we) begin
            r_bmem[b_waddr] <= b_wdata;
        end
        r_brd <= r_bmem[b_raddr];
    end

    // sequencer, lanes and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            for (int l = 0; l < NUM_CLASSES; l++) begin
                r_acc[l] <= '0;
                r_err[l] <= '0;
            end
        end else begin
            // word taken and nothing new loaded this cycle
            if (o_logit.ready && !(r_state == S_EM_WR && out_free)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (pop) begin
                        r_work <= i_q_data;
                        r_cnt  <= '0;
                        unique case (i_q_data.kind)
                            K_SPIKE: begin
                                r_state <= i_q_data.col_ok ? S_SP_ADD : S_EM_RD;
                            end
                            K_ERROR: begin
                                r_err[RW'(i_q_data.row)] <= i_q_data.err;
                                r_state <= S_ER_MUL;
                            end
                            K_UPDATE: r_state <= S_UP_MUL;
                            default:  r_state <= S_IDLE;
                        endcase
                    end
                end
                S_SP_ADD: begin
                    for (int l = 0; l < NUM_CLASSES; l++) begin
                        r_acc[l] <= sat24(25'(r_acc[l]) + 25'($signed(r_wrd[l])));
                    end
                    r_state <= r_work.last ? S_EM_RD : S_IDLE;
                end
                S_ER_MUL: begin
                    r_bprod <= $signed({1'b0, i_lr}) * r_work.err;
                    r_bold  <= r_brd;
                    r_state <= S_ER_WR;
                end
                S_ER_WR: r_state <= S_IDLE;
                S_UP_MUL: begin
                    for (int l = 0; l < NUM_CLASSES; l++) begin
                        r_prod[l] <= $signed({1'b0, i_lr}) * r_err[l];
                    end
                    r_wold  <= r_wrd;
                    r_state <= S_UP_WR;
                end
                S_UP_WR: r_state <= S_IDLE;
                S_EM_RD: r_state <= S_EM_WR;
                S_EM_WR: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_oidx   <= 6'(r_cnt);
                        r_ologit <= sat24(logit_sum);
                        r_olast  <= r_cnt == LAST_CLS;
                        if (r_cnt == LAST_CLS) begin
                            for (int l = 0; l < NUM_CLASSES; l++) begin
                                r_acc[l] <= '0;
                            end
                            r_state <= S_IDLE;
                        end else begin
                            r_cnt   <= r_cnt + 1'b1;
                            r_state <= S_EM_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_logit.valid       = r_ovalid;
    assign o_logit.class_index = r_oidx;
    assign o_logit.logit       = r_ologit;
    assign o_logit.last_class  = r_olast;

    // checks
    `SSR_ASSERT_NEXT(a_emit_loads, i_clk, i_rst_n, r_state == S_EM_WR && out_free,
        o_logit.valid, "logit word not loaded")
    `SSR_ASSERT_NOW(a_last_index, i_clk, i_rst_n, o_logit.valid && o_logit.last_class,
        o_logit.class_index == 6'(LAST_CLS), "last flag on wrong class")
    `SSR_ASSERT_NEXT(a_acc_cleared, i_clk, i_rst_n,
        r_state == S_EM_WR && out_free && r_cnt == LAST_CLS,
        r_acc[0] == 24'sd0 && r_state == S_IDLE, "accumulators not cleared")
    `SSR_ASSERT_NOW(a_busy_no_pop, i_clk, i_rst_n, r_state != S_IDLE,
        !o_q_ready, "queue popped while busy")

endmodule
